// File: hw/rtl/qct_pkg.sv
// Shared types, constants and angle table for the quad corner transform.
`default_nettype none
package qct_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_LEN     = 24;
   localparam int NUM_CELLS    = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
   localparam int STEP_W       = 5;
   localparam int CORDIC_W     = 34;
   localparam int VERT_W       = 32;
   localparam int TEX_W        = 17;
   localparam int OFF_W        = VERT_W + 1;
   localparam int SUM_W        = VERT_W + 2;
   localparam int PROD_W       = 2 * VERT_W;
   localparam int RES_W        = 14;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);
   localparam logic signed [PROD_W-1:0]   ROUND_HALF  = PROD_W'(64'h0000_0000_4000_0000);
   localparam logic signed [VERT_W-1:0]   VERT_MAX    = VERT_W'(32'h7FFF_FFFF);
   localparam logic signed [VERT_W-1:0]   VERT_MIN    = VERT_W'(32'h8000_0000);

   localparam logic [1:0] CORNER_TL = 2'd0;
   localparam logic [1:0] CORNER_TR = 2'd1;
   localparam logic [1:0] CORNER_BL = 2'd2;
   localparam logic [1:0] CORNER_BR = 2'd3;

   typedef struct packed {
      logic               is_glyph;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] size_w;
      logic signed [31:0] size_h;
      logic        [15:0] angle;
      logic        [15:0] clip_x;
      logic        [15:0] clip_y;
      logic        [15:0] clip_w;
      logic        [15:0] clip_h;
      logic               last_quad;
   } qct_req_type;

   typedef struct packed {
      logic        [1:0]  corner;
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic        [16:0] tex_u;
      logic        [16:0] tex_v;
      logic               last_of_quad;
      logic               last_of_batch;
   } qct_rsp_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
      logic        [1:0]          quad;
      logic                       is_glyph;
      logic signed [31:0]         pos_x;
      logic signed [31:0]         pos_y;
      logic signed [31:0]         size_w;
      logic signed [31:0]         size_h;
      logic        [15:0]         clip_x;
      logic        [15:0]         clip_y;
      logic        [15:0]         clip_w;
      logic        [15:0]         clip_h;
      logic                       last_quad;
   } qct_cell_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
      logic [31:0] val;
      unique case (idx)
         5'd0:    val = 32'h2000_0000;
         5'd1:    val = 32'h12E4_051E;
         5'd2:    val = 32'h09FB_385B;
         5'd3:    val = 32'h0511_11D4;
         5'd4:    val = 32'h028B_0D43;
         5'd5:    val = 32'h0145_D7E1;
         5'd6:    val = 32'h00A2_F61E;
         5'd7:    val = 32'h0051_7C55;
         5'd8:    val = 32'h0028_BE53;
         5'd9:    val = 32'h0014_5F2F;
         5'd10:   val = 32'h000A_2F98;
         5'd11:   val = 32'h0005_17CC;
         5'd12:   val = 32'h0002_8BE6;
         5'd13:   val = 32'h0001_45F3;
         5'd14:   val = 32'h0000_A2FA;
         5'd15:   val = 32'h0000_517D;
         5'd16:   val = 32'h0000_28BE;
         5'd17:   val = 32'h0000_145F;
         5'd18:   val = 32'h0000_0A30;
         5'd19:   val = 32'h0000_0518;
         5'd20:   val = 32'h0000_028C;
         5'd21:   val = 32'h0000_0146;
         5'd22:   val = 32'h0000_00A3;
         5'd23:   val = 32'h0000_0051;
         default: val = 32'h0000_0000;
      endcase
      return CORDIC_W'(val);
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/qct_cordic_cell.sv
// One rotation-mode CORDIC iteration cell with the quad fields riding alongside.
`default_nettype none
module qct_cordic_cell (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 advance,
   input  wire  [qct_pkg::STEP_W-1:0]          step,
   input  wire                                 in_valid,
   input  qct_pkg::qct_cell_type               in_data,
   output logic                                out_valid,
   output qct_pkg::qct_cell_type               out_data
);
   import qct_pkg::*;

   logic                       valid_ff;
   qct_cell_type               data_ff;
   qct_cell_type               data_in;
   logic signed [CORDIC_W-1:0] x_i;
   logic signed [CORDIC_W-1:0] y_i;
   logic signed [CORDIC_W-1:0] z_i;
   logic signed [CORDIC_W-1:0] dx;
   logic signed [CORDIC_W-1:0] dy;
   logic signed [CORDIC_W-1:0] ang;

   assign x_i = in_data.x;
   assign y_i = in_data.y;
   assign z_i = in_data.z;
   assign dx  = y_i >>> step;
   assign dy  = x_i >>> step;
   assign ang = atan_turn(step);

   always_comb begin
      data_in = in_data;
      if (!z_i[CORDIC_W-1]) begin
         data_in.x = x_i - dx;
         data_in.y = y_i + dy;
         data_in.z = z_i - ang;
      end else begin
         data_in.x = x_i + dx;
         data_in.y = y_i - dy;
         data_in.z = z_i + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/qct_vertex_unit.sv
// Quad hold register, corner sequencer and vertex multiply/round/saturate pipeline.
`default_nettype none
module qct_vertex_unit (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    tail_valid,
   input  qct_pkg::qct_cell_type  tail_data,
   output logic                   tail_take,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output qct_pkg::qct_rsp_type   rsp_data
);
   import qct_pkg::*;

   // quad hold
   logic                     hold_valid_ff, hold_valid_in;
   logic [1:0]               cnt_ff, cnt_in;
   logic signed [VERT_W-1:0] p_ff, m_ff, np_ff, nm_ff;
   logic signed [VERT_W-1:0] p_in, m_in, np_in, nm_in;
   qct_cell_type             quad_ff;

   logic signed [CORDIC_W-1:0] sum_a, sum_b, sum_na, sum_nb;
   logic signed [VERT_W-1:0]   a_t, b_t, na_t, nb_t;

   logic ven, issue, last_issue, load;

   // stage 1
   logic                     s1_valid_ff;
   logic signed [PROD_W-1:0] prod_x_ff, prod_y_ff, prod_x_in, prod_y_in;
   logic signed [VERT_W-1:0] rx, ry;
   logic                     s1_glyph_ff, s1_gx_ff, s1_gy_ff;
   logic signed [VERT_W-1:0] s1_pos_x_ff, s1_pos_y_ff, s1_sw_ff, s1_sh_ff;
   logic [1:0]               s1_corner_ff;
   logic [TEX_W-1:0]         s1_tex_u_ff, s1_tex_v_ff, tex_u_in, tex_v_in;
   logic                     s1_loq_ff, s1_lob_ff;

   // stage 2
   logic                     s2_valid_ff;
   logic signed [OFF_W-1:0]  off_x_ff, off_y_ff, off_x_in, off_y_in;
   logic signed [PROD_W-1:0] rnd_x, rnd_y;
   logic signed [VERT_W-1:0] s2_pos_x_ff, s2_pos_y_ff;
   logic [1:0]               s2_corner_ff;
   logic [TEX_W-1:0]         s2_tex_u_ff, s2_tex_v_ff;
   logic                     s2_loq_ff, s2_lob_ff;

   // output
   logic                     out_valid_ff;
   qct_rsp_type              out_ff, out_in;
   logic signed [SUM_W-1:0]  sum_x, sum_y;

   assign ven        = !out_valid_ff || rsp_ready;
   assign issue      = hold_valid_ff && ven;
   assign last_issue = issue && (cnt_ff == CORNER_BR);
   assign load       = tail_valid && (!hold_valid_ff || last_issue);
   assign tail_take  = load;

   assign hold_valid_in = load || (hold_valid_ff && !last_issue);

   always_comb begin
      cnt_in = cnt_ff;
      if (load) begin
         cnt_in = CORNER_TL;
      end else if (issue) begin
         cnt_in = cnt_ff + 2'd1;
      end
   end

   // quadrant fold: all sums and differences, rotated by quadrant
   assign sum_a  = tail_data.x + tail_data.y;
   assign sum_b  = tail_data.x - tail_data.y;
   assign sum_na = -tail_data.x - tail_data.y;
   assign sum_nb = tail_data.y - tail_data.x;
   assign a_t    = sum_a[VERT_W-1:0];
   assign b_t    = sum_b[VERT_W-1:0];
   assign na_t   = sum_na[VERT_W-1:0];
   assign nb_t   = sum_nb[VERT_W-1:0];

   always_comb begin
      unique case (tail_data.quad)
         2'd0: begin
            p_in = a_t;  m_in = b_t;  np_in = na_t; nm_in = nb_t;
         end
         2'd1: begin
            p_in = b_t;  m_in = na_t; np_in = nb_t; nm_in = a_t;
         end
         2'd2: begin
            p_in = na_t; m_in = nb_t; np_in = a_t;  nm_in = b_t;
         end
         default: begin
            p_in = nb_t; m_in = a_t;  np_in = b_t;  nm_in = na_t;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         cnt_ff        <= CORNER_TL;
      end else begin
         hold_valid_ff <= hold_valid_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         p_ff    <= p_in;
         m_ff    <= m_in;
         np_ff   <= np_in;
         nm_ff   <= nm_in;
         quad_ff <= tail_data;
      end
   end

   // corner select: twice the rotated unit corner
   always_comb begin
      unique case (cnt_ff)
         CORNER_TL: begin rx = np_ff; ry = m_ff;  end
         CORNER_TR: begin rx = m_ff;  ry = p_ff;  end
         CORNER_BL: begin rx = nm_ff; ry = np_ff; end
         default:   begin rx = p_ff;  ry = nm_ff; end
      endcase
   end

   assign prod_x_in = PROD_W'(rx) * PROD_W'(quad_ff.size_w);
   assign prod_y_in = PROD_W'(ry) * PROD_W'(quad_ff.size_h);
   assign tex_u_in  = TEX_W'(quad_ff.clip_x) + (cnt_ff[0] ? TEX_W'(quad_ff.clip_w) : '0);
   assign tex_v_in  = TEX_W'(quad_ff.clip_y) + (cnt_ff[1] ? TEX_W'(quad_ff.clip_h) : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (ven) begin
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ven) begin
         prod_x_ff    <= prod_x_in;
         prod_y_ff    <= prod_y_in;
         s1_glyph_ff  <= quad_ff.is_glyph;
         s1_gx_ff     <= cnt_ff[0];
         s1_gy_ff     <= !cnt_ff[1];
         s1_pos_x_ff  <= quad_ff.pos_x;
         s1_pos_y_ff  <= quad_ff.pos_y;
         s1_sw_ff     <= quad_ff.size_w;
         s1_sh_ff     <= quad_ff.size_h;
         s1_corner_ff <= cnt_ff;
         s1_tex_u_ff  <= tex_u_in;
         s1_tex_v_ff  <= tex_v_in;
         s1_loq_ff    <= (cnt_ff == CORNER_BR);
         s1_lob_ff    <= (cnt_ff == CORNER_BR) && quad_ff.last_quad;
      end
   end

   // round to nearest, half up, dropping the doubled corner scale
   assign rnd_x = prod_x_ff + ROUND_HALF;
   assign rnd_y = prod_y_ff + ROUND_HALF;

   always_comb begin
      if (s1_glyph_ff) begin
         off_x_in = s1_gx_ff ? OFF_W'(s1_sw_ff) : '0;
         off_y_in = s1_gy_ff ? OFF_W'(s1_sh_ff) : '0;
      end else begin
         off_x_in = rnd_x[PROD_W-1:VERT_W-1];
         off_y_in = rnd_y[PROD_W-1:VERT_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (ven) begin
         off_x_ff     <= off_x_in;
         off_y_ff     <= off_y_in;
         s2_pos_x_ff  <= s1_pos_x_ff;
         s2_pos_y_ff  <= s1_pos_y_ff;
         s2_corner_ff <= s1_corner_ff;
         s2_tex_u_ff  <= s1_tex_u_ff;
         s2_tex_v_ff  <= s1_tex_v_ff;
         s2_loq_ff    <= s1_loq_ff;
         s2_lob_ff    <= s1_lob_ff;
      end
   end

   assign sum_x = SUM_W'(s2_pos_x_ff) + SUM_W'(off_x_ff);
   assign sum_y = SUM_W'(s2_pos_y_ff) + SUM_W'(off_y_ff);

   always_comb begin
      out_in.corner = s2_corner_ff;
      if (sum_x[SUM_W-1:VERT_W-1] == '0 || sum_x[SUM_W-1:VERT_W-1] == '1) begin
         out_in.vert_x = sum_x[VERT_W-1:0];
      end else begin
         out_in.vert_x = sum_x[SUM_W-1] ? VERT_MIN : VERT_MAX;
      end
      if (sum_y[SUM_W-1:VERT_W-1] == '0 || sum_y[SUM_W-1:VERT_W-1] == '1) begin
         out_in.vert_y = sum_y[VERT_W-1:0];
      end else begin
         out_in.vert_y = sum_y[SUM_W-1] ? VERT_MIN : VERT_MAX;
      end
      out_in.tex_u         = s2_tex_u_ff;
      out_in.tex_v         = s2_tex_v_ff;
      out_in.last_of_quad  = s2_loq_ff;
      out_in.last_of_batch = s2_lob_ff;
   end

   always_ff @(posedge clock) begin
      if (ven) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
`default_nettype wire

// File: hw/rtl/quad_corner_transform.sv
// Top level: CORDIC cell chain feeding the corner vertex unit.
// Takes one quad and returns four vertex transfers (top-left, top-right, bottom-left,
// bottom-right). Sine and cosine come from a chain of NUM_CELLS CORDIC cells (16 by
// default), one iteration per cell, so a quad moves one cell per cycle unless the chain
// stalls, and new quads enter behind it. The vertex unit holds one quad and issues one
// corner per cycle, unless the output is back-pressured, through a single pair of 32x32
// multipliers; the next quad loads as the last corner issues. Each vertex then passes the
// stage 1, 2 and output registers. Glyph quads take the same path and ignore the angle.
`default_nettype none
module quad_corner_transform (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  qct_pkg::qct_req_type  req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output qct_pkg::qct_rsp_type  rsp_data
);
   import qct_pkg::*;

   logic         cell_valid [NUM_CELLS+1];
   qct_cell_type cell_data  [NUM_CELLS+1];
   logic         advance;
   logic         tail_take;

   assign advance = !cell_valid[NUM_CELLS] || tail_take;
   assign req_ready = advance;

   always_comb begin
      cell_valid[0]          = req_valid;
      cell_data[0].x         = CORDIC_GAIN;
      cell_data[0].y         = '0;
      cell_data[0].z         = CORDIC_W'({req_data.angle[RES_W-1:0], 16'h0000});
      cell_data[0].quad      = req_data.angle[15:14];
      cell_data[0].is_glyph  = req_data.is_glyph;
      cell_data[0].pos_x     = req_data.pos_x;
      cell_data[0].pos_y     = req_data.pos_y;
      cell_data[0].size_w    = req_data.size_w;
      cell_data[0].size_h    = req_data.size_h;
      cell_data[0].clip_x    = req_data.clip_x;
      cell_data[0].clip_y    = req_data.clip_y;
      cell_data[0].clip_w    = req_data.clip_w;
      cell_data[0].clip_h    = req_data.clip_h;
      cell_data[0].last_quad = req_data.last_quad;
   end

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      qct_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .step      (STEP_W'(i)),
         .in_valid  (cell_valid[i]),
         .in_data   (cell_data[i]),
         .out_valid (cell_valid[i+1]),
         .out_data  (cell_data[i+1])
      );
   end

   qct_vertex_unit u_vertex (
      .clock      (clock),
      .reset      (reset),
      .tail_valid (cell_valid[NUM_CELLS]),
      .tail_data  (cell_data[NUM_CELLS]),
      .tail_take  (tail_take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

// File: tb/sv/tb_quad_corner_transform.sv
// Self-checking testbench for the quad corner transform: predicted vertices against DUT output.
module tb_quad_corner_transform;
   import qct_pkg::*;

   localparam longint CORDIC_START  = 64'sd652032874;
   localparam longint HALF_LSB      = 64'sh4000_0000;
   localparam int     LONG_HOLD     = 200;
   localparam int     TAIL_CYCLES   = NUM_CELLS + 16;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   qct_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   qct_rsp_type rsp_data;

   qct_rsp_type vertex_expect [$];
   int          errors;
   bit          idle_gaps;
   int          hold_requests;

   quad_corner_transform dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic longint atan_step(input int idx);
      case (idx)
         0:       return 64'h2000_0000;
         1:       return 64'h12E4_051E;
         2:       return 64'h09FB_385B;
         3:       return 64'h0511_11D4;
         4:       return 64'h028B_0D43;
         5:       return 64'h0145_D7E1;
         6:       return 64'h00A2_F61E;
         7:       return 64'h0051_7C55;
         8:       return 64'h0028_BE53;
         9:       return 64'h0014_5F2F;
         10:      return 64'h000A_2F98;
         11:      return 64'h0005_17CC;
         12:      return 64'h0002_8BE6;
         13:      return 64'h0001_45F3;
         14:      return 64'h0000_A2FA;
         15:      return 64'h0000_517D;
         16:      return 64'h0000_28BE;
         17:      return 64'h0000_145F;
         18:      return 64'h0000_0A30;
         19:      return 64'h0000_0518;
         20:      return 64'h0000_028C;
         21:      return 64'h0000_0146;
         22:      return 64'h0000_00A3;
         23:      return 64'h0000_0051;
         default: return 64'h0;
      endcase
   endfunction

   function automatic logic signed [31:0] clamp_q16(input longint v);
      if (v > longint'(VERT_MAX)) return VERT_MAX;
      if (v < longint'(VERT_MIN)) return VERT_MIN;
      return v[31:0];
   endfunction

   function automatic void predict_quad(input qct_req_type q);
      longint      cos_v, sin_v, x, y, z, dx, dy;
      longint      px, py, sw, sh, vx, vy, sx, sy, r2x, r2y;
      logic        ux, uy;
      qct_rsp_type v;
      cos_v = 0;
      sin_v = 0;
      px = $signed(q.pos_x);
      py = $signed(q.pos_y);
      sw = $signed(q.size_w);
      sh = $signed(q.size_h);
      if (!q.is_glyph) begin
         x = CORDIC_START;
         y = 0;
         z = 0;
         z[29:16] = q.angle[13:0];
         for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - atan_step(i);
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + atan_step(i);
            end
         end
         case (q.angle[15:14])
            2'd0: begin cos_v = x;  sin_v = y;  end
            2'd1: begin cos_v = -y; sin_v = x;  end
            2'd2: begin cos_v = -x; sin_v = -y; end
            default: begin cos_v = y; sin_v = -x; end
         endcase
      end
      for (int k = 0; k < 4; k++) begin
         v.corner = 2'(k);
         ux = v.corner[0];
         uy = v.corner[1];
         if (q.is_glyph) begin
            vx = px + (ux ? sw : 64'sd0);
            vy = py + (uy ? 64'sd0 : sh);
         end else begin
            sx  = ux ? 64'sd1 : -64'sd1;
            sy  = uy ? -64'sd1 : 64'sd1;
            r2x = sx * cos_v - sy * sin_v;
            r2y = sx * sin_v + sy * cos_v;
            vx  = px + ((sw * r2x + HALF_LSB) >>> 31);
            vy  = py + ((sh * r2y + HALF_LSB) >>> 31);
         end
         v.vert_x        = clamp_q16(vx);
         v.vert_y        = clamp_q16(vy);
         v.tex_u         = {1'b0, q.clip_x} + (ux ? {1'b0, q.clip_w} : 17'd0);
         v.tex_v         = {1'b0, q.clip_y} + (uy ? {1'b0, q.clip_h} : 17'd0);
         v.last_of_quad  = (v.corner == CORNER_BR);
         v.last_of_batch = (v.corner == CORNER_BR) && q.last_quad;
         vertex_expect.push_back(v);
      end
   endfunction

   task automatic check_field(input string name, input logic [1:0] corner,
                              input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: corner %0d %s mismatch, expected %h, actual %h",
                  $time, corner, name, want, got);
         errors++;
      end
   endtask

   task automatic check_vertex(input qct_rsp_type got);
      qct_rsp_type want;
      if (vertex_expect.size() == 0) begin
         $display("%0t: unexpected vertex, expected none, actual %h", $time, got);
         errors++;
      end else begin
         want = vertex_expect.pop_front();
         check_field("corner", want.corner, want.corner, got.corner);
         check_field("vert_x", want.corner, want.vert_x, got.vert_x);
         check_field("vert_y", want.corner, want.vert_y, got.vert_y);
         check_field("tex_u", want.corner, want.tex_u, got.tex_u);
         check_field("tex_v", want.corner, want.tex_v, got.tex_v);
         check_field("last_of_quad", want.corner, want.last_of_quad, got.last_of_quad);
         check_field("last_of_batch", want.corner, want.last_of_batch, got.last_of_batch);
      end
   endtask

   initial begin : vertex_sink
      int hold;
      int hold_served;
      hold        = 0;
      hold_served = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) check_vertex(rsp_data);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (idle_gaps && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 15) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_quad(input qct_req_type q);
      int gap;
      if (idle_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (!req_ready);
      predict_quad(q);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (vertex_expect.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_fixed();
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return VERT_MAX;
         2:       return VERT_MIN;
         3:       return 32'(int'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
         default: return 32'(int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
      endcase
   endfunction

   function automatic qct_req_type rand_quad();
      qct_req_type q;
      q.is_glyph = ($urandom_range(0, 3) == 0);
      q.pos_x    = rand_fixed();
      q.pos_y    = rand_fixed();
      q.size_w   = rand_fixed();
      q.size_h   = rand_fixed();
      q.angle    = 16'($urandom);
      if ($urandom_range(0, 7) == 0)
         q.angle = {2'($urandom), ($urandom_range(0, 1) ? 14'h3FFF : 14'h0000)};
      q.clip_x    = 16'($urandom);
      q.clip_y    = 16'($urandom);
      q.clip_w    = 16'($urandom);
      q.clip_h    = 16'($urandom);
      q.last_quad = ($urandom_range(0, 5) == 0);
      return q;
   endfunction

   task automatic test_corner_cases();
      qct_req_type q;
      logic [15:0] angles [7];
      angles[0] = 16'h0000;
      angles[1] = 16'h4000;
      angles[2] = 16'h8000;
      angles[3] = 16'hC000;
      angles[4] = 16'hFFFF;
      angles[5] = 16'h3FFF;
      angles[6] = 16'h2000;
      idle_gaps = 1'b1;
      q = '0;
      send_quad(q);
      q.size_w = 32'sh0001_0000;
      q.size_h = 32'sh0001_0000;
      for (int i = 0; i < 7; i++) begin
         q.angle     = angles[i];
         q.last_quad = i[0];
         send_quad(q);
      end
      q = '0;
      q.is_glyph = 1'b1;
      q.pos_x = VERT_MAX; q.pos_y = VERT_MAX; q.size_w = VERT_MAX; q.size_h = VERT_MAX;
      send_quad(q);
      q.pos_x = VERT_MIN; q.pos_y = VERT_MIN; q.size_w = VERT_MIN; q.size_h = VERT_MIN;
      q.angle = 16'hFFFF;
      send_quad(q);
      q.pos_x = VERT_MAX; q.pos_y = VERT_MIN; q.size_w = VERT_MIN; q.size_h = VERT_MAX;
      send_quad(q);
      q.is_glyph = 1'b0;
      q.angle = 16'h2000;
      q.pos_x = VERT_MAX; q.pos_y = VERT_MAX; q.size_w = VERT_MAX; q.size_h = VERT_MAX;
      send_quad(q);
      q.pos_x = VERT_MIN; q.pos_y = VERT_MIN; q.size_w = VERT_MIN; q.size_h = VERT_MIN;
      q.angle = 16'hA000;
      send_quad(q);
      q = '0;
      q.size_w = -32'sh0002_0000;
      q.size_h = -32'sh0000_8000;
      q.angle  = 16'h1234;
      q.clip_x = 16'hFFFF; q.clip_y = 16'hFFFF; q.clip_w = 16'hFFFF; q.clip_h = 16'hFFFF;
      q.last_quad = 1'b1;
      send_quad(q);
      q.is_glyph = 1'b1;
      send_quad(q);
      q = '1;
      send_quad(q);
      q.is_glyph = 1'b0;
      send_quad(q);
      wait_drain();
   endtask

   task automatic test_back_pressure();
      idle_gaps = 1'b0;
      hold_requests <= hold_requests + 1;
      repeat (30) send_quad(rand_quad());
      wait_drain();
   endtask

   task automatic test_random_quads();
      idle_gaps = 1'b1;
      repeat (220) send_quad(rand_quad());
      wait_drain();
   endtask

   task automatic test_full_rate();
      idle_gaps = 1'b0;
      repeat (40) send_quad(rand_quad());
      wait_drain();
   endtask

   initial begin
      errors        = 0;
      idle_gaps     = 1'b0;
      hold_requests = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_cases();
      test_back_pressure();
      test_random_quads();
      test_full_rate();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
